[rtl/core/fralu_pkg.sv]
package fralu_pkg;

  localparam int DATA_WIDTH = 64;
  localparam int CNT_W = $clog2(DATA_WIDTH);
  localparam int REG_COUNT = 4;
  localparam int REG_AW = 2;

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,
    OP_ADD   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_MOD   = 3'd4,
    OP_EQUAL = 3'd5
  } alu_op_t;

  typedef enum logic [REG_AW-1:0] {
    REG_X = 2'd0,
    REG_Y = 2'd1,
    REG_Z = 2'd2,
    REG_W = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    UNIT_IDLE,
    UNIT_RUN,
    UNIT_FIX
  } unit_state_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WAIT,
    ST_WB
  } top_state_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } unit_req_t;

  typedef struct packed {
    logic  done;
    word_t result;
  } unit_rsp_t;

  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] addr;
    word_t             data;
  } rf_wr_t;

  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] addr_a;
    logic [REG_AW-1:0] addr_b;
  } rf_rd_t;

endpackage

[rtl/core/fralu_regfile.sv]
module fralu_regfile import fralu_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  rf_rd_t rd,
  input  rf_wr_t wr,
  output word_t  rd_data_a,
  output word_t  rd_data_b
);

  word_t                mem [REG_COUNT];
  logic [REG_COUNT-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_a <= valid[rd.addr_a] ? mem[rd.addr_a] : '0;
      rd_data_b <= valid[rd.addr_b] ? mem[rd.addr_b] : '0;
    end
  end

endmodule

[rtl/core/fralu_seq_unit.sv]
module fralu_seq_unit import fralu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  unit_req_t req,
  input  word_t     a,
  input  word_t     b,
  output unit_rsp_t rsp
);

  unit_state_t          state;
  unit_state_t          state_next;
  logic [CNT_W-1:0]     cnt;
  word_t                acc;
  word_t                opa;
  word_t                opb;
  logic                 is_div;
  logic                 is_mod;
  logic                 neg;
  logic                 do_load;
  logic                 do_step;
  logic                 do_fix;
  logic                 last;
  word_t                mag_a;
  word_t                mag_b;
  word_t                rem_sh;
  word_t                left;
  word_t                addend;
  logic [DATA_WIDTH:0]  sum;
  word_t                sel;

  assign last = (cnt == CNT_W'(DATA_WIDTH - 1));

  always_comb begin
    state_next = state;
    case (state)
      UNIT_IDLE: if (req.start) state_next = UNIT_RUN;
      UNIT_RUN:  if (last) state_next = UNIT_FIX;
      UNIT_FIX:  state_next = UNIT_IDLE;
      default:   state_next = UNIT_IDLE;
    endcase
  end

  always_comb begin
    do_load = 1'b0;
    do_step = 1'b0;
    do_fix  = 1'b0;
    case (state)
      UNIT_IDLE: do_load = req.start;
      UNIT_RUN:  do_step = 1'b1;
      UNIT_FIX:  do_fix  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= UNIT_IDLE;
      rsp.done <= 1'b0;
    end else begin
      state    <= state_next;
      rsp.done <= do_fix;
      if (do_fix) begin
        rsp.result <= neg ? (~sel + word_t'(1)) : sel;
      end
    end
  end

  assign mag_a = a[DATA_WIDTH-1] ? (~a + word_t'(1)) : a;
  assign mag_b = b[DATA_WIDTH-1] ? (~b + word_t'(1)) : b;

  // One adder serves both loops: add for shift-and-add multiply, subtract for
  // restoring division, where the carry out tells that the divisor fits.
  assign rem_sh = {acc[DATA_WIDTH-2:0], opb[DATA_WIDTH-1]};
  assign left   = is_div ? rem_sh : acc;
  assign addend = is_div ? ~opa : (opb[0] ? opa : '0);
  assign sum    = {1'b0, left} + {1'b0, addend} + (DATA_WIDTH+1)'(is_div);
  assign sel    = (is_div && !is_mod) ? opb : acc;

  always_ff @(posedge clk) begin
    if (do_load) begin
      cnt    <= '0;
      acc    <= '0;
      is_div <= (req.op == OP_DIV) || (req.op == OP_MOD);
      is_mod <= (req.op == OP_MOD);
      if (req.op == OP_MUL) begin
        opa <= a;
        opb <= b;
        neg <= 1'b0;
      end else begin
        opa <= mag_b;
        opb <= mag_a;
        neg <= (req.op == OP_MOD) ? a[DATA_WIDTH-1]
                                  : (a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1]);
      end
    end else if (do_step) begin
      cnt <= cnt + CNT_W'(1);
      if (is_div) begin
        acc <= sum[DATA_WIDTH] ? sum[DATA_WIDTH-1:0] : rem_sh;
        opb <= {opb[DATA_WIDTH-2:0], sum[DATA_WIDTH]};
      end else begin
        acc <= sum[DATA_WIDTH-1:0];
        opa <= {opa[DATA_WIDTH-2:0], 1'b0};
        opb <= {1'b0, opb[DATA_WIDTH-1:1]};
      end
    end
  end

endmodule

[rtl/core/four_register_integer_alu.sv]
// Each beat carries one instruction for the four 64-bit registers x, y, z and
// w; one result beat follows per instruction. Load, add, equal, unused codes
// and divide or modulo by zero go from acceptance through the execute state
// to write-back, where the result enters the output register and the block
// returns to idle to accept the next beat. Multiply, divide and modulo run
// through one shared add/subtract unit that retires one bit per cycle; their
// result passes from the execute state through the wait state, which lasts
// until the unit is done, to write-back, and the next beat is accepted only
// after that. in_ready is high only while no instruction is in progress; a
// finished result waits in the output register without holding up the next
// beat, but the instruction after it cannot hand over its own result, and so
// cannot finish, until the waiting beat is taken.
module four_register_integer_alu import fralu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [1:0]  target_reg,
  input  logic        source_is_reg,
  input  logic [1:0]  source_reg,
  input  logic [63:0] immediate_value,
  input  logic [63:0] input_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] written_value,
  output logic        answer_is_zero,
  output logic        fault
);

  top_state_t        state;
  top_state_t        state_next;
  alu_op_t           op;
  logic [REG_AW-1:0] tgt;
  logic              src_is_reg;
  word_t             imm;
  word_t             load_val;
  word_t             rd_a;
  word_t             rd_b;
  word_t             opnd_b;
  word_t             res;
  word_t             res_next;
  logic              write;
  logic              write_next;
  logic              fault_reg;
  logic              fault_next;
  logic              needs_unit;
  logic              z_zero;
  logic              z_zero_next;
  logic              accept;
  logic              exec;
  logic              wb_fire;
  rf_rd_t            rf_rd;
  rf_wr_t            rf_wr;
  unit_req_t         unit_req;
  unit_rsp_t         unit_rsp;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_EXEC;
      ST_EXEC: state_next = needs_unit ? ST_WAIT : ST_WB;
      ST_WAIT: if (unit_rsp.done) state_next = ST_WB;
      ST_WB:   if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    exec     = 1'b0;
    wb_fire  = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_EXEC: exec     = 1'b1;
      ST_WB:   wb_fire  = !out_valid || out_ready;
      default: ;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op         <= alu_op_t'(operation);
      tgt        <= target_reg;
      src_is_reg <= source_is_reg;
      imm        <= immediate_value[DATA_WIDTH-1:0];
      load_val   <= input_value[DATA_WIDTH-1:0];
    end
  end

  assign rf_rd.en     = accept;
  assign rf_rd.addr_a = target_reg;
  assign rf_rd.addr_b = source_reg;

  fralu_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd        (rf_rd),
    .wr        (rf_wr),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  assign opnd_b = src_is_reg ? rd_b : imm;

  always_comb begin
    res_next   = rd_a;
    write_next = 1'b0;
    fault_next = 1'b0;
    needs_unit = 1'b0;
    case (op)
      OP_LOAD: begin
        res_next   = load_val;
        write_next = 1'b1;
      end
      OP_ADD: begin
        res_next   = rd_a + opnd_b;
        write_next = 1'b1;
      end
      OP_MUL: begin
        write_next = 1'b1;
        needs_unit = 1'b1;
      end
      OP_DIV, OP_MOD: begin
        if (opnd_b == '0) begin
          fault_next = 1'b1;
        end else begin
          write_next = 1'b1;
          needs_unit = 1'b1;
        end
      end
      OP_EQUAL: begin
        res_next   = word_t'(rd_a == opnd_b);
        write_next = 1'b1;
      end
      default: ;
    endcase
  end

  assign unit_req.start = exec && needs_unit;
  assign unit_req.op    = op;

  fralu_seq_unit u_unit (
    .clk (clk),
    .rst (rst),
    .req (unit_req),
    .a   (rd_a),
    .b   (opnd_b),
    .rsp (unit_rsp)
  );

  always_ff @(posedge clk) begin
    if (exec) begin
      res       <= res_next;
      write     <= write_next;
      fault_reg <= fault_next;
    end else if (state == ST_WAIT && unit_rsp.done) begin
      res <= unit_rsp.result;
    end
  end

  assign rf_wr.en   = wb_fire && write;
  assign rf_wr.addr = tgt;
  assign rf_wr.data = res;

  assign z_zero_next = (rf_wr.en && tgt == REG_Z) ? (res == '0) : z_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      z_zero    <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      z_zero <= z_zero_next;
      if (wb_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wb_fire) begin
      written_value  <= 64'(signed'(res));
      answer_is_zero <= z_zero_next;
      fault          <= fault_reg;
    end
  end

endmodule

[rtl/core/fralu_checker.sv]
module fralu_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] written_value,
  input logic        answer_is_zero,
  input logic        fault
);

  // Only one instruction is in progress at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after an accepted beat");

  a_clean_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> in_ready && !out_valid)
    else $error("block not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(written_value)
      && $stable(answer_is_zero) && $stable(fault))
    else $error("stalled result beat changed");

endmodule

bind four_register_integer_alu fralu_checker u_fralu_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .written_value  (written_value),
  .answer_is_zero (answer_is_zero),
  .fault          (fault)
);

[tb/sv/alu_result_checker.sv]
`timescale 1ns / 100ps
module alu_result_checker import fralu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [1:0]  target_reg,
  input  logic        source_is_reg,
  input  logic [1:0]  source_reg,
  input  logic [63:0] immediate_value,
  input  logic [63:0] input_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] written_value,
  input  logic        answer_is_zero,
  input  logic        fault,
  output int          mismatches,
  output int          pending
);

  localparam int MSB = DATA_WIDTH - 1;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    word_t value;
    logic  zero;
    logic  fault;
  } alu_result_t;

  word_t       regfile [REG_COUNT];
  alu_result_t results_due [$];
  alu_result_t due;

  function automatic alu_result_t execute_instr(input logic [2:0] op, input logic [1:0] tgt,
                                                input logic sir, input logic [1:0] sreg,
                                                input word_t imm, input word_t inv);
    word_t       a;
    word_t       b;
    word_t       res;
    word_t       ma;
    word_t       mb;
    word_t       quo;
    word_t       rem;
    logic        wr;
    logic        flt;
    alu_result_t r;
    a = regfile[tgt];
    b = sir ? regfile[sreg] : imm;
    res = a;
    wr = 1'b1;
    flt = 1'b0;
    case (op)
      OP_LOAD:  res = inv;
      OP_ADD:   res = a + b;
      OP_MUL:   res = a * b;
      OP_DIV, OP_MOD: begin
        if (b == '0) begin
          flt = 1'b1;
          wr = 1'b0;
        end else begin
          ma = a[MSB] ? -a : a;
          mb = b[MSB] ? -b : b;
          if (op == OP_DIV) begin
            quo = ma / mb;
            res = (a[MSB] ^ b[MSB]) ? -quo : quo;
          end else begin
            rem = ma % mb;
            res = a[MSB] ? -rem : rem;
          end
        end
      end
      OP_EQUAL: res = word_t'(a == b);
      default:  wr = 1'b0;
    endcase
    if (wr) regfile[tgt] = res;
    r.value = regfile[tgt];
    r.zero = (regfile[REG_Z] == '0);
    r.fault = flt;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (regfile[i]) regfile[i] = '0;
      results_due.delete();
      mismatches = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("unexpected result beat: value %h zero %b fault %b",
                     written_value, answer_is_zero, fault);
          mismatches++;
        end else begin
          due = results_due.pop_front();
          if (due.value !== written_value || due.zero !== answer_is_zero ||
              due.fault !== fault) begin
            if (mismatches < REPORT_LIMIT)
              $display("result mismatch: expected value %h zero %b fault %b, got value %h zero %b fault %b",
                       due.value, due.zero, due.fault, written_value, answer_is_zero, fault);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        results_due.push_back(execute_instr(operation, target_reg, source_is_reg, source_reg,
                                            immediate_value, input_value));
    end
    pending = results_due.size();
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
module tb;
  import fralu_pkg::*;

  localparam int RANDOM_ITEMS = 380;
  localparam int QUIET_TAIL = 60;
  localparam int HOLD_AFTER = 60;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 100;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam word_t MAX_WORD = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam word_t MIN_WORD = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam word_t ALL_ONES = '1;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  operation;
  logic [1:0]  target_reg;
  logic        source_is_reg;
  logic [1:0]  source_reg;
  logic [63:0] immediate_value;
  logic [63:0] input_value;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] written_value;
  logic        answer_is_zero;
  logic        fault;
  int          mismatches;
  int          pending;
  int          beats_sent;
  int          idle_cycles;
  logic        quiet;
  logic        hold_done;

  four_register_integer_alu dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .target_reg(target_reg), .source_is_reg(source_is_reg),
    .source_reg(source_reg), .immediate_value(immediate_value), .input_value(input_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .written_value(written_value), .answer_is_zero(answer_is_zero), .fault(fault)
  );

  alu_result_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .target_reg(target_reg), .source_is_reg(source_is_reg),
    .source_reg(source_reg), .immediate_value(immediate_value), .input_value(input_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .written_value(written_value), .answer_is_zero(answer_is_zero), .fault(fault),
    .mismatches(mismatches), .pending(pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic word_t rand_word();
    word_t w;
    case ($urandom_range(0, 7))
      0:       w = '0;
      1:       w = word_t'($signed($urandom_range(0, 20)) - 10);
      2:       w = MIN_WORD;
      3:       w = MAX_WORD;
      4:       w = ALL_ONES;
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  task automatic send_instr(input logic [2:0] op, input logic [1:0] tgt, input logic sir,
                            input logic [1:0] sreg, input word_t imm, input word_t inv);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation <= op;
    target_reg <= tgt;
    source_is_reg <= sir;
    source_reg <= sreg;
    immediate_value <= imm;
    input_value <= inv;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  initial begin
    out_ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        out_ready <= 1'b1;
      end else if (!hold_done && beats_sent >= HOLD_AFTER) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 12)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [2:0] op;
    int         pick;
    rst = 1'b1;
    in_valid = 1'b0;
    operation = '0;
    target_reg = '0;
    source_is_reg = 1'b0;
    source_reg = '0;
    immediate_value = '0;
    input_value = '0;
    beats_sent = 0;
    quiet = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    send_instr(OP_LOAD, REG_X, 1'b1, REG_W, ALL_ONES, MAX_WORD);
    send_instr(OP_LOAD, REG_Y, 1'b0, REG_Z, MAX_WORD, MIN_WORD);
    send_instr(OP_LOAD, REG_Z, 1'b1, REG_X, MIN_WORD, '0);
    send_instr(OP_LOAD, REG_W, 1'b0, REG_Y, '0, ALL_ONES);
    send_instr(OP_ADD, REG_X, 1'b0, REG_Y, word_t'(1), rand_word());
    send_instr(OP_MUL, REG_Y, 1'b0, REG_X, ALL_ONES, rand_word());
    send_instr(OP_DIV, REG_Y, 1'b1, REG_W, '0, rand_word());
    send_instr(OP_MOD, REG_Y, 1'b1, REG_W, '0, rand_word());
    send_instr(OP_LOAD, REG_X, 1'b0, REG_X, '0, word_t'(7));
    send_instr(OP_DIV, REG_X, 1'b0, REG_Y, -64'sd2, rand_word());
    send_instr(OP_LOAD, REG_X, 1'b0, REG_X, '0, -64'sd7);
    send_instr(OP_MOD, REG_X, 1'b0, REG_Z, word_t'(2), rand_word());
    send_instr(OP_DIV, REG_X, 1'b0, REG_W, '0, rand_word());
    send_instr(OP_MOD, REG_Z, 1'b1, REG_Z, ALL_ONES, rand_word());
    send_instr(OP_EQUAL, REG_W, 1'b0, REG_X, ALL_ONES, rand_word());
    send_instr(OP_EQUAL, REG_X, 1'b1, REG_Y, '0, rand_word());
    send_instr(OP_ADD, REG_Z, 1'b0, REG_W, MAX_WORD, rand_word());
    send_instr(OP_MUL, REG_Z, 1'b1, REG_Z, '0, rand_word());
    send_instr(OP_SPARE_A, REG_W, 1'b0, REG_X, '0, rand_word());
    send_instr(OP_SPARE_B, REG_X, 1'b1, REG_Z, rand_word(), rand_word());
    send_instr(OP_ADD, REG_W, 1'b1, REG_W, rand_word(), rand_word());
    send_instr(OP_MOD, REG_X, 1'b0, REG_Y, MIN_WORD, rand_word());
    send_instr(OP_DIV, REG_Z, 1'b0, REG_Y, MAX_WORD, rand_word());

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= RANDOM_ITEMS - QUIET_TAIL);
      pick = $urandom_range(0, 19);
      if (pick < 5)       op = OP_LOAD;
      else if (pick < 8)  op = OP_ADD;
      else if (pick < 11) op = OP_MUL;
      else if (pick < 14) op = OP_DIV;
      else if (pick < 17) op = OP_MOD;
      else if (pick < 19) op = OP_EQUAL;
      else                op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
      send_instr(op, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                 2'($urandom_range(0, 3)), rand_word(), rand_word());
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/fralu_pkg.sv
rtl/core/fralu_regfile.sv
rtl/core/fralu_seq_unit.sv
rtl/core/four_register_integer_alu.sv
rtl/core/fralu_checker.sv
tb/sv/alu_result_checker.sv
tb/sv/tb.sv
